### rtl/core/uart_receiver_with_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// uart receiver with fifo - assertion macros
// shared assertion forms for the checker files of this block
// ----------------------------------------------------------------------------
`ifndef UART_RECEIVER_WITH_FIFO_TOP_DEFINES_SVH
`define UART_RECEIVER_WITH_FIFO_TOP_DEFINES_SVH

// same-cycle property, off during reset
`define URX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// condition in one cycle implies a condition in the next
`define URX_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

### rtl/core/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg
// types and constants shared by the uart receiver front, back and top level
// ----------------------------------------------------------------------------
package urx_pkg;

	// receive fifo geometry
	localparam int FIFO_DEPTH = 128;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// bit timing
	localparam logic [15:0] BIT_TICKS_RST = 16'd833;
	localparam logic [15:0] TICK_MAX      = 16'hFFFF;
	localparam logic [2:0]  LAST_BIT      = 3'd7;

	// internal queues, depths are powers of two
	localparam int CMDQ_DEPTH = 4;
	localparam int CQ_IDX_W   = $clog2(CMDQ_DEPTH);
	localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 4;
	localparam int OQ_IDX_W   = $clog2(OUTQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	// receiver phases
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_STOP
	} phase_t;

	// one classified item from front to back
	typedef struct packed {
		logic             pop;
		logic             store;
		logic             dropped;
		logic [7:0]       data;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic [7:0] fill_count;
		logic       byte_stored;
		logic       frame_dropped;
	} res_t;

endpackage

### rtl/core/uart_receiver_with_fifo_top.sv
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo_top
// 8n1 uart receiver feeding a 128 byte receive fifo
// ----------------------------------------------------------------------------
// One item is accepted in every cycle while full is low: a tick item carries
// one sample of the receive line, a read item pops one byte if any is held.
// Every item gives one result beat, which passes through the four-entry
// command queue and the registered read of the fifo ram, then waits in a
// four-entry result queue that absorbs stalls on the result side; full
// rises only after the command queue has filled. Configuration writes to
// bit_ticks take effect on the next item. The fifo ram holds no reset
// state; the fill count and pointers reset.
// ----------------------------------------------------------------------------
module uart_receiver_with_fifo_top import urx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic        rx_level,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic [7:0]  fill_count,
	output logic        byte_stored,
	output logic        frame_dropped
);

	logic cmd_push;
	cmd_t cmd;
	res_t res;

	// receiver and classification
	urx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.rx_level  (rx_level),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	// fifo storage and results
	urx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	// result fields
	assign read_data     = res.read_data;
	assign read_valid    = res.read_valid;
	assign fill_count    = res.fill_count;
	assign byte_stored   = res.byte_stored;
	assign frame_dropped = res.frame_dropped;

endmodule

### rtl/core/urx_ram.sv
// ----------------------------------------------------------------------------
// urx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module urx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/urx_front.sv
// ----------------------------------------------------------------------------
// urx_front
// accepts items, runs the 8n1 receive state machine and the fill count,
// and hands one classified command per item to the back end
// ----------------------------------------------------------------------------
module urx_front import urx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic        rx_level,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        cmd_push,
	output cmd_t        cmd
);

	phase_t           phase_q, phase_d;
	logic [15:0]      bit_ticks_q;
	logic [15:0]      tick_q, tick_d;
	logic [2:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic             last_q, last_d;
	logic [CNT_W-1:0] count_q, count_d;

	logic        accept;
	logic [15:0] tick_inc;
	logic [15:0] target;
	logic        fire;
	logic        room;

	assign accept   = push && !full;
	assign tick_inc = (tick_q < TICK_MAX) ? tick_q + 16'd1 : tick_q;
	assign target   = (phase_q == PH_START) ? {1'b0, bit_ticks_q[15:1]} : bit_ticks_q;
	assign fire     = tick_inc >= target;
	assign room     = count_q < CNT_W'(FIFO_DEPTH);

	// bit period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RST;
		end else if (cfg_we) begin
			bit_ticks_q <= cfg_wdata;
		end
	end

	// receiver state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			last_q  <= 1'b1;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			last_q  <= last_d;
			count_q <= count_d;
		end
	end

	// next state and command
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		last_d      = last_q;
		count_d     = count_q;
		cmd.pop     = 1'b0;
		cmd.store   = 1'b0;
		cmd.dropped = 1'b0;
		cmd.data    = shift_q;
		if (accept) begin
			if (opcode == OP_READ) begin
				// read pops only when something is held
				if (count_q != '0) begin
					cmd.pop = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end else begin
				last_d = rx_level;
				unique case (phase_q)
					PH_IDLE: begin
						// falling edge with room starts a frame
						if (last_q && !rx_level && room) begin
							phase_d = PH_START;
							tick_d  = '0;
						end
					end
					PH_START: begin
						tick_d = fire ? 16'd0 : tick_inc;
						if (fire) begin
							if (rx_level) begin
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_DATA;
								bit_d   = '0;
								shift_d = '0;
							end
						end
					end
					PH_DATA: begin
						tick_d = fire ? 16'd0 : tick_inc;
						if (fire) begin
							if (rx_level) begin
								shift_d[bit_q] = 1'b1;
							end
							if (bit_q == LAST_BIT) begin
								bit_d   = '0;
								phase_d = PH_STOP;
							end else begin
								bit_d = bit_q + 3'd1;
							end
						end
					end
					PH_STOP: begin
						tick_d = fire ? 16'd0 : tick_inc;
						if (fire) begin
							if (rx_level) begin
								if (room) begin
									cmd.store = 1'b1;
									count_d   = count_q + CNT_W'(1);
								end
							end else begin
								cmd.dropped = 1'b1;
							end
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
		cmd.count = count_d;
	end

	assign cmd_push = accept;

endmodule

### rtl/core/urx_back.sv
// ----------------------------------------------------------------------------
// urx_back
// command queue, byte ring buffer access and result queue
// ----------------------------------------------------------------------------
module urx_back import urx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_push,
	input  cmd_t       cmd,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output res_t       res
);

	cmd_t                cq_q [CMDQ_DEPTH];
	logic [CQ_IDX_W-1:0] cq_wr_q, cq_rd_q;
	logic [CQ_CNT_W-1:0] cq_cnt_q;

	res_t                oq_q [OUTQ_DEPTH];
	logic [OQ_IDX_W-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	logic [PTR_W-1:0] wp_q, rp_q;
	logic             valid_s1;
	cmd_t             cmd_s1;
	cmd_t             head;
	logic             issue;
	logic             oq_pop;
	logic [7:0]       ram_rdata;
	res_t             res_s1;

	assign full  = cq_cnt_q == CQ_CNT_W'(CMDQ_DEPTH);
	assign empty = oq_cnt_q == '0;
	assign head  = cq_q[cq_rd_q];

	// issue only with a free result slot for the command in flight
	assign issue = (cq_cnt_q != '0) &&
		(({1'b0, oq_cnt_q} + (OQ_CNT_W + 1)'(valid_s1)) < (OQ_CNT_W + 1)'(OUTQ_DEPTH));
	assign oq_pop = pop && !empty;

	// command queue storage
	always_ff @(posedge clk) begin
		if (cmd_push) begin
			cq_q[cq_wr_q] <= cmd;
		end
	end

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q  <= '0;
			cq_rd_q  <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (cmd_push) begin
				cq_wr_q <= cq_wr_q + CQ_IDX_W'(1);
			end
			if (issue) begin
				cq_rd_q <= cq_rd_q + CQ_IDX_W'(1);
			end
			cq_cnt_q <= cq_cnt_q + CQ_CNT_W'(cmd_push) - CQ_CNT_W'(issue);
		end
	end

	// ring buffer pointers, wrap at the fifo depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (issue) begin
			if (head.store) begin
				wp_q <= (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (head.pop) begin
				rp_q <= (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
		end
	end

	urx_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (issue && head.store),
		.waddr (wp_q),
		.wdata (head.data),
		.re    (issue && head.pop),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// stage alongside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= head;
		end
	end

	// result beat
	always_comb begin
		res_s1.read_data     = cmd_s1.pop ? ram_rdata : 8'd0;
		res_s1.read_valid    = cmd_s1.pop;
		res_s1.fill_count    = 8'(cmd_s1.count);
		res_s1.byte_stored   = cmd_s1.store;
		res_s1.frame_dropped = cmd_s1.dropped;
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wr_q] <= res_s1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_wr_q <= oq_wr_q + OQ_IDX_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_IDX_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(valid_s1) - OQ_CNT_W'(oq_pop);
		end
	end

	assign res = oq_q[oq_rd_q];

endmodule

### rtl/core/urx_checker.sv
// ----------------------------------------------------------------------------
// urx_checker
// port-level checks on the result side of the uart receiver
// ----------------------------------------------------------------------------
`include "uart_receiver_with_fifo_top_defines.svh"

module urx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  read_data,
	input logic        read_valid,
	input logic [7:0]  fill_count,
	input logic        byte_stored,
	input logic        frame_dropped
);

	// a read beat never reports frame events
	`URX_ASSERT(a_read_no_frame, !empty && read_valid |-> !byte_stored && !frame_dropped, "read beat with frame flag")

	// nothing popped means zero data
	`URX_ASSERT(a_zero_data, !empty && !read_valid |-> read_data == 8'd0, "data without a pop")

	// a frame is either stored or dropped
	`URX_ASSERT(a_frame_excl, !empty |-> !(byte_stored && frame_dropped), "frame both stored and dropped")

	// a waiting beat holds until taken
	`URX_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(read_data) && $stable(fill_count), "waiting beat changed")

endmodule

bind uart_receiver_with_fifo_top urx_checker u_urx_checker (.*);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - uart receiver with fifo
// Drives tick and read items through the push/full side and checks every
// result beat on the empty/pop side against a cycle-free software model of
// the 8n1 receiver and its 128 byte fifo. Directed frame cases come first,
// then randomized serial traffic under several bit periods.
// ----------------------------------------------------------------------------
module tb;
	import urx_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        opcode;
	logic        rx_level;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        empty;
	logic        pop;
	logic [7:0]  read_data;
	logic        read_valid;
	logic [7:0]  fill_count;
	logic        byte_stored;
	logic        frame_dropped;

	// receiver model state
	logic [15:0] bit_ticks_q;
	phase_t      rx_ph;
	logic [15:0] tick_cnt;
	logic [2:0]  bit_idx;
	logic [7:0]  shift_q;
	logic        prev_lvl;
	logic [7:0]  fifo_mem [FIFO_DEPTH];
	int          rd_ptr;
	int          wr_ptr;
	int          fifo_cnt;

	// results still owed by the block, oldest first
	res_t pending_results[$];

	// stimulus control
	int          line_bt;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          hold_req;
	int          sent_items;

	// bookkeeping
	int mismatch_cnt;
	int beats_checked;
	int bytes_stored;
	int frames_dropped;
	int bytes_read;
	int max_fill;

	uart_receiver_with_fifo_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.rx_level      (rx_level),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.empty         (empty),
		.pop           (pop),
		.read_data     (read_data),
		.read_valid    (read_valid),
		.fill_count    (fill_count),
		.byte_stored   (byte_stored),
		.frame_dropped (frame_dropped)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// model of one item: updates receiver and fifo state, returns the beat
	function automatic res_t predict_rx_item(logic op, logic lvl);
		res_t        r;
		logic [15:0] tgt;
		r = '0;
		if (op == OP_READ) begin
			if (fifo_cnt != 0) begin
				r.read_data  = fifo_mem[rd_ptr];
				r.read_valid = 1'b1;
				rd_ptr       = (rd_ptr + 1) % FIFO_DEPTH;
				fifo_cnt     = fifo_cnt - 1;
			end
		end else begin
			if (rx_ph == PH_IDLE) begin
				// falling edge starts a frame only with room in the fifo
				if (prev_lvl && !lvl && fifo_cnt < FIFO_DEPTH) begin
					rx_ph    = PH_START;
					tick_cnt = '0;
				end
			end else begin
				tgt = (rx_ph == PH_START) ? (bit_ticks_q >> 1) : bit_ticks_q;
				if (tick_cnt != TICK_MAX)
					tick_cnt = tick_cnt + 16'd1;
				if (tick_cnt >= tgt) begin
					tick_cnt = '0;
					case (rx_ph)
						PH_START: begin
							// high at mid start bit is a false start
							if (lvl) begin
								rx_ph = PH_IDLE;
							end else begin
								rx_ph   = PH_DATA;
								bit_idx = '0;
								shift_q = '0;
							end
						end
						PH_DATA: begin
							if (lvl)
								shift_q[bit_idx] = 1'b1;
							if (bit_idx == LAST_BIT) begin
								bit_idx = '0;
								rx_ph   = PH_STOP;
							end else begin
								bit_idx = bit_idx + 3'd1;
							end
						end
						default: begin
							if (lvl) begin
								if (fifo_cnt < FIFO_DEPTH) begin
									fifo_mem[wr_ptr] = shift_q;
									wr_ptr           = (wr_ptr + 1) % FIFO_DEPTH;
									fifo_cnt         = fifo_cnt + 1;
									r.byte_stored    = 1'b1;
								end
							end else begin
								r.frame_dropped = 1'b1;
							end
							rx_ph = PH_IDLE;
						end
					endcase
				end
			end
			prev_lvl = lvl;
		end
		r.fill_count = 8'(fifo_cnt);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// compare the beat on the result ports with the oldest expectation
	task automatic check_beat();
		res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result beat with nothing pending");
		end else begin
			want = pending_results.pop_front();
			beats_checked++;
			if (read_data !== want.read_data)
				report_mismatch($sformatf("read_data %0h, want %0h",
					read_data, want.read_data));
			if (read_valid !== want.read_valid)
				report_mismatch($sformatf("read_valid %0b, want %0b",
					read_valid, want.read_valid));
			if (fill_count !== want.fill_count)
				report_mismatch($sformatf("fill_count %0d, want %0d",
					fill_count, want.fill_count));
			if (byte_stored !== want.byte_stored)
				report_mismatch($sformatf("byte_stored %0b, want %0b",
					byte_stored, want.byte_stored));
			if (frame_dropped !== want.frame_dropped)
				report_mismatch($sformatf("frame_dropped %0b, want %0b",
					frame_dropped, want.frame_dropped));
		end
	endtask

	// monitor: result beats, accepted items and register writes
	always @(posedge clk) begin
		res_t r;
		if (arst_n) begin
			if (pop && !empty)
				check_beat();
			if (push && !full) begin
				r = predict_rx_item(opcode, rx_level);
				pending_results.push_back(r);
				bytes_stored   += r.byte_stored;
				frames_dropped += r.frame_dropped;
				bytes_read     += r.read_valid;
				if (fifo_cnt > max_fill)
					max_fill = fifo_cnt;
			end
			if (cfg_we)
				bit_ticks_q = cfg_wdata;
		end
	end

	// result side: random stall bursts and requested long hold-offs
	initial begin
		int hold_left;
		int gap_left;
		hold_left = 0;
		gap_left  = 0;
		pop       = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				pop      <= 1'b0;
				gap_left = $urandom_range(1, 7) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// one item beat; returns at the edge that accepted it
	task automatic send_item(input logic op, input logic lvl);
		int   gap;
		logic was_full;
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 7);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push     <= 1'b1;
		opcode   <= op;
		rx_level <= lvl;
		do begin
			@(negedge clk);
			was_full = full;
			@(posedge clk);
		end while (was_full);
		sent_items++;
	endtask

	// one line tick, sometimes preceded by a read
	task automatic send_tick(input logic lvl, input int read_pct);
		if ($urandom_range(0, 99) < read_pct)
			send_item(OP_READ, 1'($urandom_range(0, 1)));
		send_item(OP_TICK, lvl);
	endtask

	task automatic send_reads(input int n);
		repeat (n) send_item(OP_READ, 1'($urandom_range(0, 1)));
	endtask

	// full 8n1 waveform at the current bit period, idle high in front
	task automatic send_frame(input logic [7:0] val, input logic stop_hi,
			input int idle_ticks, input int read_pct);
		repeat (idle_ticks + 1) send_tick(1'b1, read_pct);
		repeat (line_bt) send_tick(1'b0, read_pct);
		for (int i = 0; i < 8; i++)
			repeat (line_bt) send_tick(val[i], read_pct);
		repeat (line_bt) send_tick(stop_hi, read_pct);
	endtask

	// sender pauses until every result is back
	task automatic wait_drain();
		push <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bit_ticks(input int v);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= 16'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		line_bt = v;
	endtask

	// reads on an empty fifo give nothing
	task automatic test_empty_read();
		send_item(OP_READ, 1'b0);
		send_item(OP_READ, 1'b1);
	endtask

	// mid start bit at the reset period, data and stop bits at a short period
	task automatic test_reset_period();
		logic [7:0] val;
		val = 8'h5A;
		send_tick(1'b1, 0);
		repeat (BIT_TICKS_RST / 2 + 1) send_tick(1'b0, 0);
		write_bit_ticks(4);
		for (int i = 0; i < 8; i++)
			repeat (line_bt) send_tick(val[i], 0);
		repeat (line_bt) send_tick(1'b1, 0);
		send_reads(1);
	endtask

	// data extremes, low stop bit, false start, reads inside a frame
	task automatic test_frame_cases();
		write_bit_ticks(4);
		send_frame(8'h00, 1'b1, 2, 0);
		send_frame(8'hFF, 1'b1, 2, 0);
		send_frame(8'h81, 1'b1, 2, 0);
		send_frame(8'h3C, 1'b0, 2, 0);
		// short low pulse, line back high at mid start bit
		send_tick(1'b1, 0);
		repeat (line_bt / 2) send_tick(1'b0, 0);
		repeat (10) send_tick(1'b1, 0);
		send_frame(8'hA5, 1'b1, 1, 30);
		send_reads(6);
	endtask

	// a few stored bytes, then drain past empty
	task automatic test_fifo_burst();
		write_bit_ticks(4);
		repeat (3) send_frame(8'($urandom), 1'b1, $urandom_range(0, 3), 0);
		send_reads(4);
	endtask

	// longest bit period, then shrink it while a frame waits for mid start bit
	task automatic test_long_period();
		write_bit_ticks(16'hFFFF);
		send_tick(1'b1, 0);
		repeat (60) send_tick(1'b0, 0);
		repeat (20) send_tick(1'($urandom_range(0, 1)), 0);
		write_bit_ticks(4);
		repeat (60) send_tick(1'($urandom_range(0, 1)), 2);
		repeat (20) send_tick(1'b1, 0);
		send_reads(3);
	endtask

	// mostly clean frames with random content, plus broken frames and noise
	task automatic test_random_traffic(input int n_items, input int bt);
		int stop_at;
		int kind;
		write_bit_ticks(bt);
		stop_at = sent_items + n_items;
		while (sent_items < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_frame(8'($urandom), 1'b1, $urandom_range(0, 4), 10);
			end else if (kind < 80) begin
				send_frame(8'($urandom), 1'b0, $urandom_range(0, 4), 10);
			end else if (kind < 88) begin
				send_tick(1'b1, 0);
				repeat ($urandom_range(1, line_bt / 2 - 1)) send_tick(1'b0, 0);
				repeat (line_bt) send_tick(1'b1, 5);
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)), 10);
			end else begin
				send_reads($urandom_range(1, 10));
			end
		end
	endtask

	// long receiver hold-off while items keep coming, so full must stall input
	task automatic test_backpressure();
		write_bit_ticks(5);
		@(negedge clk);
		hold_req = 400;
		@(posedge clk);
		test_random_traffic(100, 5);
	endtask

	initial begin
		push          = 1'b0;
		opcode        = OP_TICK;
		rx_level      = 1'b1;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		arst_n        = 1'b0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		hold_req      = 0;
		sent_items    = 0;
		mismatch_cnt  = 0;
		beats_checked = 0;
		bytes_stored  = 0;
		frames_dropped = 0;
		bytes_read    = 0;
		max_fill      = 0;
		// model reset state
		line_bt     = BIT_TICKS_RST;
		bit_ticks_q = BIT_TICKS_RST;
		rx_ph       = PH_IDLE;
		tick_cnt    = '0;
		bit_idx     = '0;
		shift_q     = '0;
		prev_lvl    = 1'b1;
		rd_ptr      = 0;
		wr_ptr      = 0;
		fifo_cnt    = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_read();
		test_reset_period();
		test_frame_cases();
		test_fifo_burst();
		test_long_period();
		test_backpressure();
		test_random_traffic(80, 4);
		test_random_traffic(80, 7);
		test_random_traffic(80, $urandom_range(4, 16));
		// closing stretch at full rate on both sides
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b0;
		test_random_traffic(100, 6);
		wait_drain();
		repeat (10) @(posedge clk);

		$display("%0d items sent, %0d result beats checked, %0d mismatches",
			sent_items, beats_checked, mismatch_cnt);
		$display("%0d bytes stored, %0d frames dropped, %0d bytes read, peak fill %0d",
			bytes_stored, frames_dropped, bytes_read, max_fill);
		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
